// ===== rtl/core/mmce_pkg.sv =====
// shared types and constants for the motor command encoder
// no dependencies
`timescale 1ns / 1ps

package mmce_pkg;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_RANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_RANGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LOWER     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_UPPER     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_ENABLE    = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SOFT     = 3'd1;
    localparam logic [2:0] ST_POSITION = 3'd2;
    localparam logic [2:0] ST_VELOCITY = 3'd3;
    localparam logic [2:0] ST_TORQUE   = 3'd4;
    localparam logic [2:0] ST_KP       = 3'd5;
    localparam logic [2:0] ST_KD       = 3'd6;

    localparam int unsigned NUM_CH = 5;
    localparam logic [2:0] CH_POS = 3'd0;
    localparam logic [2:0] CH_VEL = 3'd1;
    localparam logic [2:0] CH_TRQ = 3'd2;
    localparam logic [2:0] CH_KP  = 3'd3;
    localparam logic [2:0] CH_KD  = 3'd4;

    typedef struct packed {
        logic [30:0]        position_range;
        logic [30:0]        velocity_range;
        logic [30:0]        torque_range;
        logic [30:0]        stiffness_max;
        logic [30:0]        damping_max;
        logic signed [31:0] soft_lower;
        logic signed [31:0] soft_upper;
        logic               soft_limit_enable;
    } cfg_t;

    typedef struct packed {
        logic [3:0]         motor_id;
        logic signed [31:0] target_position;
        logic signed [31:0] target_velocity;
        logic signed [31:0] feedforward_torque;
        logic signed [31:0] stiffness_gain;
        logic signed [31:0] damping_gain;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] can_id;
        logic [63:0] frame_data;
    } rsp_t;

    // classified job: status plus offsets (x - lo) and spans
    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] can_id;
        logic [31:0] off_pos;
        logic [31:0] off_vel;
        logic [31:0] off_trq;
        logic [31:0] off_kp;
        logic [31:0] off_kd;
        logic [31:0] span_pos;
        logic [31:0] span_vel;
        logic [31:0] span_trq;
        logic [31:0] span_kp;
        logic [31:0] span_kd;
    } job_t;

endpackage

// ===== rtl/core/mmce_if.sv =====
// valid/ready channel carrying one payload
// depends on nothing
`timescale 1ns / 1ps

interface mmce_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/motor_mit_command_encoder.sv =====
// top level of the motor command encoder: config registers, front, queue, back
// depends on mmce_pkg, mmce_if, mmce_front, mmce_fifo, mmce_back
`timescale 1ns / 1ps

// A command is checked and registered by the front part and queued; the back part
// quantizes the five values one after another with a shared multiplier and a
// bit-serial divider, while a rejected command goes straight to its response.
// The back part takes no new command until it has issued the response of the
// last one. Configuration takes effect at the front, so write it only while idle.
module motor_mit_command_encoder #(
    parameter int unsigned MIT_ID_OFFSET = 0
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mmce_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mmce_pkg::CFG_DATA_W-1:0]        cfg_data,
    mmce_if.sink                                   cmd,
    mmce_if.source                                 rsp
);

    mmce_pkg::cfg_t cfg_reg;
    logic           job_valid, job_ready, q_valid, q_ready;
    mmce_pkg::job_t job, q_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_range    <= 31'd819200;
            cfg_reg.velocity_range    <= 31'd1966080;
            cfg_reg.torque_range      <= 31'd655360;
            cfg_reg.stiffness_max     <= 31'd32768000;
            cfg_reg.damping_max       <= 31'd327680;
            cfg_reg.soft_lower        <= -32'sd819200;
            cfg_reg.soft_upper        <= 32'sd819200;
            cfg_reg.soft_limit_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mmce_pkg::REG_POSITION_RANGE: cfg_reg.position_range <= cfg_data[30:0];
                mmce_pkg::REG_VELOCITY_RANGE: cfg_reg.velocity_range <= cfg_data[30:0];
                mmce_pkg::REG_TORQUE_RANGE:   cfg_reg.torque_range <= cfg_data[30:0];
                mmce_pkg::REG_STIFFNESS_MAX:  cfg_reg.stiffness_max <= cfg_data[30:0];
                mmce_pkg::REG_DAMPING_MAX:    cfg_reg.damping_max <= cfg_data[30:0];
                mmce_pkg::REG_SOFT_LOWER:     cfg_reg.soft_lower <= cfg_data;
                mmce_pkg::REG_SOFT_UPPER:     cfg_reg.soft_upper <= cfg_data;
                default:                      cfg_reg.soft_limit_enable <= cfg_data[0];
            endcase
        end
    end

    mmce_front #(.MIT_ID_OFFSET(MIT_ID_OFFSET)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(cmd.valid), .in_ready(cmd.ready), .cmd(cmd.data),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    mmce_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(job_valid), .wr_ready(job_ready), .wr_data(job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    mmce_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.data)
    );

endmodule

// ===== rtl/core/mmce_front.sv =====
// front part: range checks and span set-up for one command
// depends on mmce_pkg
`timescale 1ns / 1ps

module mmce_front #(
    parameter int unsigned MIT_ID_OFFSET = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mmce_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  mmce_pkg::cmd_t    cmd,
    output logic              job_valid,
    input  logic              job_ready,
    output mmce_pkg::job_t    job
);

    logic                job_valid_reg;
    mmce_pkg::job_t      job_reg;
    mmce_pkg::job_t      job_next;
    logic signed [32:0]  pm, vm, tm, kpm, kdm;
    logic signed [32:0]  p, v, t, kp, kd;
    logic                soft_bad, p_bad, v_bad, t_bad, kp_bad, kd_bad;
    logic [10:0]         offset_w;

    assign pm  = {2'b00, cfg.position_range};
    assign vm  = {2'b00, cfg.velocity_range};
    assign tm  = {2'b00, cfg.torque_range};
    assign kpm = {2'b00, cfg.stiffness_max};
    assign kdm = {2'b00, cfg.damping_max};
    assign p   = {cmd.target_position[31], cmd.target_position};
    assign v   = {cmd.target_velocity[31], cmd.target_velocity};
    assign t   = {cmd.feedforward_torque[31], cmd.feedforward_torque};
    assign kp  = {cmd.stiffness_gain[31], cmd.stiffness_gain};
    assign kd  = {cmd.damping_gain[31], cmd.damping_gain};
    assign offset_w = 11'(MIT_ID_OFFSET);

    assign soft_bad = cfg.soft_limit_enable
        && ((cmd.target_position < cfg.soft_lower) || (cmd.target_position > cfg.soft_upper));
    assign p_bad  = (p < -pm) || (p > pm);
    assign v_bad  = (v < -vm) || (v > vm);
    assign t_bad  = (t < -tm) || (t > tm);
    assign kp_bad = (kp < 33'sd0) || (kp > kpm);
    assign kd_bad = (kd < 33'sd0) || (kd > kdm);

    // values are inside range when ok, so x + max fits 32 bits unsigned
    always_comb
    begin
        logic [32:0] s;
        job_next = '0;
        if (soft_bad)
            job_next.status = mmce_pkg::ST_SOFT;
        else if (p_bad)
            job_next.status = mmce_pkg::ST_POSITION;
        else if (v_bad)
            job_next.status = mmce_pkg::ST_VELOCITY;
        else if (t_bad)
            job_next.status = mmce_pkg::ST_TORQUE;
        else if (kp_bad)
            job_next.status = mmce_pkg::ST_KP;
        else if (kd_bad)
            job_next.status = mmce_pkg::ST_KD;
        else
            job_next.status = mmce_pkg::ST_OK;
        job_next.can_id = 11'(cmd.motor_id) + offset_w;
        s = 33'(p + pm);
        job_next.off_pos = s[31:0];
        s = 33'(v + vm);
        job_next.off_vel = s[31:0];
        s = 33'(t + tm);
        job_next.off_trq = s[31:0];
        job_next.off_kp = kp[31:0];
        job_next.off_kd = kd[31:0];
        job_next.span_pos = {cfg.position_range, 1'b0};
        job_next.span_vel = {cfg.velocity_range, 1'b0};
        job_next.span_trq = {cfg.torque_range, 1'b0};
        job_next.span_kp = {1'b0, cfg.stiffness_max};
        job_next.span_kd = {1'b0, cfg.damping_max};
    end

    assign in_ready  = !job_valid_reg || job_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            job_valid_reg <= 1'b0;
        else if (in_ready)
            job_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            job_reg <= job_next;
    end

endmodule

// ===== rtl/core/mmce_fifo.sv =====
// two-entry queue between the front and back parts
// depends on mmce_pkg
`timescale 1ns / 1ps

module mmce_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  mmce_pkg::job_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output mmce_pkg::job_t  rd_data
);

    mmce_pkg::job_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== rtl/core/mmce_back.sv =====
// back part: quantizes five values with one shared multiplier and divider
// depends on mmce_pkg
`timescale 1ns / 1ps

module mmce_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  mmce_pkg::job_t  job,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output mmce_pkg::rsp_t  rsp
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

    state_t          state_reg;
    mmce_pkg::job_t  job_reg;
    logic [2:0]      ch_reg;
    logic [5:0]      bit_reg;
    logic [47:0]     num_reg;
    logic [32:0]     rem_reg;
    logic [15:0]     quo_reg;
    logic [63:0]     frame_reg;
    logic            rsp_valid_reg;
    mmce_pkg::rsp_t  rsp_reg;
    logic [31:0]     off_sel, span_sel;
    logic [32:0]     trial;
    logic            is_pos;
    logic            start;

    assign is_pos = ch_reg == mmce_pkg::CH_POS;

    always_comb
    begin
        case (ch_reg)
            mmce_pkg::CH_POS: begin off_sel = job_reg.off_pos; span_sel = job_reg.span_pos; end
            mmce_pkg::CH_VEL: begin off_sel = job_reg.off_vel; span_sel = job_reg.span_vel; end
            mmce_pkg::CH_TRQ: begin off_sel = job_reg.off_trq; span_sel = job_reg.span_trq; end
            mmce_pkg::CH_KP:  begin off_sel = job_reg.off_kp;  span_sel = job_reg.span_kp;  end
            default:          begin off_sel = job_reg.off_kd;  span_sel = job_reg.span_kd;  end
        endcase
    end

    assign trial     = {rem_reg[31:0], num_reg[bit_reg]} - {1'b0, span_sel};
    assign job_ready = state_reg == S_IDLE;
    assign start     = job_valid && job_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // restoring division, one quotient bit per cycle; quotient fits 16 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= mmce_pkg::CH_POS;
            bit_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && state_reg != S_DONE)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        job_reg   <= job;
                        ch_reg    <= mmce_pkg::CH_POS;
                        frame_reg <= '0;
                        state_reg <= (job.status == mmce_pkg::ST_OK) ? S_MUL : S_DONE;
                    end
                end
                S_MUL:
                begin
                    // times 65535 or 4095 as shift and subtract
                    num_reg   <= is_pos ? ({off_sel, 16'd0} - {16'd0, off_sel})
                                        : ({4'd0, off_sel, 12'd0} - {16'd0, off_sel});
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    bit_reg   <= 6'd47;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (!trial[32])
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[31:0], num_reg[bit_reg]};
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end
                    if (bit_reg == 6'd0)
                    begin
                        state_reg <= S_DONE;
                        if (span_sel == 32'd0)
                            frame_reg <= frame_reg;
                        else
                            case (ch_reg)
                                mmce_pkg::CH_POS: frame_reg[63:48] <= {quo_reg[14:0], !trial[32]};
                                mmce_pkg::CH_VEL: frame_reg[47:36] <= {quo_reg[10:0], !trial[32]};
                                mmce_pkg::CH_KP:  frame_reg[35:24] <= {quo_reg[10:0], !trial[32]};
                                mmce_pkg::CH_KD:  frame_reg[23:12] <= {quo_reg[10:0], !trial[32]};
                                default:          frame_reg[11:0]  <= {quo_reg[10:0], !trial[32]};
                            endcase
                        if (ch_reg != mmce_pkg::CH_KD)
                        begin
                            ch_reg    <= ch_reg + 3'd1;
                            state_reg <= S_MUL;
                        end
                    end
                    else
                        bit_reg <= bit_reg - 6'd1;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg     <= 1'b1;
                        rsp_reg.status    <= job_reg.status;
                        rsp_reg.can_id    <= (job_reg.status == mmce_pkg::ST_OK)
                                             ? job_reg.can_id : 11'd0;
                        rsp_reg.frame_data <= frame_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != mmce_pkg::ST_OK |-> rsp.frame_data == 64'd0)
        else $error("rejected command with frame data");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !job_ready)
        else $error("ready while dividing");
    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_reg <= mmce_pkg::CH_KD)
        else $error("channel out of range");

endmodule

// ===== sim/motor_mit_command_encoder_test.sv =====
// testbench for motor_mit_command_encoder: directed and random commands checked
// against an in-bench encoder model; depends on mmce_pkg, mmce_if and the rtl
`timescale 1ns / 1ps

module motor_mit_command_encoder_test;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [mmce_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mmce_pkg::CFG_DATA_W-1:0] cfg_data;

    mmce_if #(.payload_t(mmce_pkg::cmd_t)) cmd (.clk(clk));
    mmce_if #(.payload_t(mmce_pkg::rsp_t)) rsp (.clk(clk));

    motor_mit_command_encoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .rsp(rsp)
    );

    mmce_pkg::cfg_t regs;
    mmce_pkg::rsp_t expected_frames[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000)
        begin
            $display("motor_mit_command_encoder test failed");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic logic [63:0] quant(input longint x, input longint lo, input longint hi,
                                          input int bits);
        longint span;
        longint full;
        span = hi - lo;
        full = (64'd1 << bits) - 1;
        if (span <= 0)
            return 0;
        if (x < lo)
            x = lo;
        if (x > hi)
            x = hi;
        return ((x - lo) * full) / span;
    endfunction

    function automatic mmce_pkg::rsp_t encode_command(input mmce_pkg::cmd_t c);
        mmce_pkg::rsp_t r;
        longint p, v, t, kp, kd, pm, vm, tm, kpm, kdm;
        p = c.target_position;
        v = c.target_velocity;
        t = c.feedforward_torque;
        kp = c.stiffness_gain;
        kd = c.damping_gain;
        pm = regs.position_range;
        vm = regs.velocity_range;
        tm = regs.torque_range;
        kpm = regs.stiffness_max;
        kdm = regs.damping_max;
        r = '0;
        if (regs.soft_limit_enable && (p < longint'(regs.soft_lower)
            || p > longint'(regs.soft_upper)))
            r.status = mmce_pkg::ST_SOFT;
        else if (p < -pm || p > pm)
            r.status = mmce_pkg::ST_POSITION;
        else if (v < -vm || v > vm)
            r.status = mmce_pkg::ST_VELOCITY;
        else if (t < -tm || t > tm)
            r.status = mmce_pkg::ST_TORQUE;
        else if (kp < 0 || kp > kpm)
            r.status = mmce_pkg::ST_KP;
        else if (kd < 0 || kd > kdm)
            r.status = mmce_pkg::ST_KD;
        else
            r.status = mmce_pkg::ST_OK;
        if (r.status == mmce_pkg::ST_OK)
        begin
            r.can_id = 11'(c.motor_id);
            r.frame_data[63:48] = 16'(quant(p, -pm, pm, 16));
            r.frame_data[47:36] = 12'(quant(v, -vm, vm, 12));
            r.frame_data[35:24] = 12'(quant(kp, 0, kpm, 12));
            r.frame_data[23:12] = 12'(quant(kd, 0, kdm, 12));
            r.frame_data[11:0] = 12'(quant(t, -tm, tm, 12));
        end
        return r;
    endfunction

    // receiver: random stall, compare each response with the oldest expectation
    always @(posedge clk)
    begin
        mmce_pkg::rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_frames.size() == 0)
                report("response with nothing expected");
            else
            begin
                want = expected_frames.pop_front();
                if (rsp.data.status !== want.status)
                    report($sformatf("status %0d want %0d", rsp.data.status, want.status));
                if (rsp.data.can_id !== want.can_id)
                    report($sformatf("can_id %h want %h", rsp.data.can_id, want.can_id));
                if (rsp.data.frame_data !== want.frame_data)
                    report($sformatf("frame %h want %h", rsp.data.frame_data,
                                     want.frame_data));
            end
        end
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [mmce_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mmce_pkg::REG_POSITION_RANGE: regs.position_range = val[30:0];
            mmce_pkg::REG_VELOCITY_RANGE: regs.velocity_range = val[30:0];
            mmce_pkg::REG_TORQUE_RANGE:   regs.torque_range = val[30:0];
            mmce_pkg::REG_STIFFNESS_MAX:  regs.stiffness_max = val[30:0];
            mmce_pkg::REG_DAMPING_MAX:    regs.damping_max = val[30:0];
            mmce_pkg::REG_SOFT_LOWER:     regs.soft_lower = val;
            mmce_pkg::REG_SOFT_UPPER:     regs.soft_upper = val;
            default:                      regs.soft_limit_enable = val[0];
        endcase
    endtask

    // valid stays high between back-to-back requests unless a random idle gap drops it; drain drops it
    task automatic send_request(input mmce_pkg::cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.data <= c;
        expected_frames = {expected_frames, encode_command(c)};
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    task automatic drain;
        cmd.valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // value near or inside a range, sometimes anywhere
    function automatic logic [31:0] pick(input longint lo, input longint hi);
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return $urandom;
        if (k == 1)
            return 32'(lo + $urandom_range(3) - 2);
        if (k == 2)
            return 32'(hi + $urandom_range(3) - 1);
        if (hi - lo <= 0)
            return 32'(lo);
        return 32'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
    endfunction

    function automatic mmce_pkg::cmd_t random_command;
        mmce_pkg::cmd_t c;
        longint pm, vm, tm;
        pm = regs.position_range;
        vm = regs.velocity_range;
        tm = regs.torque_range;
        c.motor_id = 4'($urandom);
        if (regs.soft_limit_enable && $urandom_range(1))
            c.target_position = pick(regs.soft_lower, regs.soft_upper);
        else
            c.target_position = pick(-pm, pm);
        c.target_velocity = pick(-vm, vm);
        c.feedforward_torque = pick(-tm, tm);
        c.stiffness_gain = pick(0, regs.stiffness_max);
        c.damping_gain = pick(0, regs.damping_max);
        return c;
    endfunction

    task automatic test_directed;
        mmce_pkg::cmd_t c;
        c = '0;
        send_request(c);
        c = '{4'hF, 32'sd819200, 32'sd1966080, 32'sd655360, 32'sd32768000, 32'sd327680};
        send_request(c);
        c = '{4'h3, -32'sd819200, -32'sd1966080, -32'sd655360, 32'sd0, 32'sd0};
        send_request(c);
        c = '{4'h1, 32'sd819201, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
        send_request(c);
        c = '{4'h2, 32'sd0, 32'sd1966081, 32'sd0, 32'sd0, 32'sd0};
        send_request(c);
        c = '{4'h4, 32'sd0, 32'sd0, -32'sd655361, 32'sd0, 32'sd0};
        send_request(c);
        c = '{4'h5, 32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd0};
        send_request(c);
        c = '{4'h6, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd327681};
        send_request(c);
        c = '{4'h7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000};
        send_request(c);
        c = '{4'h8, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF};
        send_request(c);
        drain();
        write_reg(mmce_pkg::REG_SOFT_ENABLE, 32'd1);
        write_reg(mmce_pkg::REG_SOFT_LOWER, -32'sd1000);
        write_reg(mmce_pkg::REG_SOFT_UPPER, 32'sd1000);
        c = '{4'h9, 32'sd1000, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
        send_request(c);
        c.target_position = -32'sd1001;
        send_request(c);
        drain();
        // inverted soft window rejects everything
        write_reg(mmce_pkg::REG_SOFT_LOWER, 32'sd5);
        write_reg(mmce_pkg::REG_SOFT_UPPER, -32'sd5);
        c.target_position = 32'sd0;
        send_request(c);
        drain();
        write_reg(mmce_pkg::REG_SOFT_ENABLE, 32'hFFFF_FFFE);
        write_reg(mmce_pkg::REG_POSITION_RANGE, 32'hFFFF_FFFF);
        write_reg(mmce_pkg::REG_VELOCITY_RANGE, 32'd1);
        write_reg(mmce_pkg::REG_TORQUE_RANGE, 32'h7FFF_FFFF);
        write_reg(mmce_pkg::REG_STIFFNESS_MAX, 32'd1);
        write_reg(mmce_pkg::REG_DAMPING_MAX, 32'h8000_0001);
        c = '{4'hA, 32'h8000_0001, 32'sd1, 32'h7FFF_FFFF, 32'sd1, 32'sd1};
        send_request(c);
        c = '{4'hB, 32'h7FFF_FFFF, -32'sd1, 32'h8000_0001, 32'sd0, 32'sd0};
        send_request(c);
        drain();
    endtask

    task automatic random_config;
        logic [31:0] a, b;
        write_reg(mmce_pkg::REG_POSITION_RANGE,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22));
        write_reg(mmce_pkg::REG_VELOCITY_RANGE,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22));
        write_reg(mmce_pkg::REG_TORQUE_RANGE,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22));
        write_reg(mmce_pkg::REG_STIFFNESS_MAX,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 26));
        write_reg(mmce_pkg::REG_DAMPING_MAX,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
        a = 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        b = 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        write_reg(mmce_pkg::REG_SOFT_LOWER,
                  $signed(a) < $signed(b) || $urandom_range(9) == 0 ? a : b);
        write_reg(mmce_pkg::REG_SOFT_UPPER,
                  $signed(a) < $signed(b) || $urandom_range(9) == 0 ? b : a);
        write_reg(mmce_pkg::REG_SOFT_ENABLE, $urandom);
    endtask

    task automatic test_random(input int idle, input int stall, input int count);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        random_config();
        repeat (count)
            send_request(random_command());
        drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.data = '0;
        rsp.ready = 1'b0;
        regs = '{31'd819200, 31'd1966080, 31'd655360, 31'd32768000, 31'd327680,
                 -32'sd819200, 32'sd819200, 1'b0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        repeat (5)
        begin
            test_random(0, 0, 80);
            test_random(83, 0, 50);
            test_random(0, 83, 50);
            test_random(32, 32, 90);
        end
        if (errors == 0)
            $display("motor_mit_command_encoder test passed");
        else
            $display("motor_mit_command_encoder test failed");
        $finish;
    end
endmodule
